>>> rtl/erasp_pkg.sv
`default_nettype none

package erasp_pkg;

  // widths fixed by the register map and the trig format
  localparam int ANGLE_W     = 14;
  localparam int SHIFT_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TRIG_W      = 16;   // signed Q2.14
  localparam int TURN_W      = 13;   // holds 0 .. FULL_TURN-1
  localparam int FRAC_BITS   = 14;
  localparam int ROUND_HALF  = 8192;
  localparam int COORD_FRAC  = 8;

  localparam int FULL_TURN   = 5760; // sixteenths of a degree
  localparam int ONE_Q14     = 16384;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // trig pipeline depth from an angle register to sin/cos
  localparam int TRIG_LATENCY = 5;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int SINE_DEPTH_DEF  = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YAW,
    CFG_PITCH,
    CFG_ROLL,
    CFG_SHIFT_X,
    CFG_SHIFT_Y,
    CFG_SHIFT_Z
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> rtl/euler_rotate_and_shift_point.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// request   in         start_i && !busy_o        in_x_i, in_y_i, in_z_i
// result    out        done_o, one cycle         out_x_o, out_y_o, out_z_o
// config    in         cfg_valid_i && cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per cycle while busy_o is low; each result is registered through
// the yaw, pitch and roll multiply/round stages and the output clamp.
// busy_o is high after reset and from every config write on, until
// the sin/cos pipeline (phase divide, table read) settles.
// Results cannot be held off, so the pipeline never stalls.

module euler_rotate_and_shift_point #(
  parameter int COORD_WIDTH      = erasp_pkg::COORD_WIDTH_DEF,
  parameter int SINE_TABLE_DEPTH = erasp_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start_i,
  output logic                                         busy_o,
  input  wire logic signed [COORD_WIDTH-1:0]           in_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]           in_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]           in_z_i,
  output logic                                         done_o,
  output logic signed [COORD_WIDTH-1:0]                out_x_o,
  output logic signed [COORD_WIDTH-1:0]                out_y_o,
  output logic signed [COORD_WIDTH-1:0]                out_z_o,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [erasp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [erasp_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import erasp_pkg::*;

  localparam int W0 = COORD_WIDTH;
  localparam int W1 = W0 + 1;
  localparam int W2 = W0 + 2;
  localparam int W3 = W0 + 3;
  localparam int M1 = W0 + TRIG_W;
  localparam int M2 = W1 + TRIG_W;
  localparam int M3 = W2 + TRIG_W;
  localparam int SW = ((W3 > SHIFT_W + COORD_FRAC) ? W3 : SHIFT_W + COORD_FRAC) + 1;
  localparam int CW = $clog2(TRIG_LATENCY + 1);
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W0+1){1'b0}}, {(W0-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

  // configuration
  logic signed [ANGLE_W-1:0] yaw_q, pitch_q, roll_q;
  logic signed [SHIFT_W-1:0] shx_q, shy_q, shz_q;
  logic [CW-1:0]             settle_q;
  logic                      cfg_we, accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy_o      = (settle_q != '0) || cfg_valid_i;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q    <= '0;
      pitch_q  <= '0;
      roll_q   <= '0;
      shx_q    <= '0;
      shy_q    <= '0;
      shz_q    <= '0;
      settle_q <= CW'(TRIG_LATENCY);
    end else begin
      if (cfg_we) begin
        settle_q <= CW'(TRIG_LATENCY);
        unique case (cfg_index_i)
          CFG_YAW:     yaw_q   <= cfg_data_i[ANGLE_W-1:0];
          CFG_PITCH:   pitch_q <= cfg_data_i[ANGLE_W-1:0];
          CFG_ROLL:    roll_q  <= cfg_data_i[ANGLE_W-1:0];
          CFG_SHIFT_X: shx_q   <= cfg_data_i[SHIFT_W-1:0];
          CFG_SHIFT_Y: shy_q   <= cfg_data_i[SHIFT_W-1:0];
          CFG_SHIFT_Z: shz_q   <= cfg_data_i[SHIFT_W-1:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - CW'(1);
      end
    end
  end

  logic signed [TRIG_W-1:0] ys, yc, ps, pc, rs, rc;

  erasp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_yaw (
    .clk_i, .rst_ni, .angle_i(yaw_q), .sin_o(ys), .cos_o(yc)
  );
  erasp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_pitch (
    .clk_i, .rst_ni, .angle_i(pitch_q), .sin_o(ps), .cos_o(pc)
  );
  erasp_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_roll (
    .clk_i, .rst_ni, .angle_i(roll_q), .sin_o(rs), .cos_o(rc)
  );

  // valid bits, stage 1..7
  logic [7:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:1], accept};
    end
  end

  // stage 1/2: yaw
  logic signed [M1-1:0] p1a_q, p1b_q, p1c_q, p1d_q;
  logic signed [W0-1:0] z0_q;
  logic signed [M1:0]   s1x, s1y;
  logic signed [W1-1:0] x1_q, y1_q, z1_q;

  always_ff @(posedge clk_i) begin
    p1a_q <= M1'(yc) * M1'(in_x_i);
    p1b_q <= M1'(ys) * M1'(in_y_i);
    p1c_q <= M1'(yc) * M1'(in_y_i);
    p1d_q <= M1'(ys) * M1'(in_x_i);
    z0_q  <= in_z_i;
  end

  assign s1x = (M1+1)'(p1a_q) + (M1+1)'(p1b_q) + (M1+1)'(ROUND_HALF);
  assign s1y = (M1+1)'(p1c_q) - (M1+1)'(p1d_q) + (M1+1)'(ROUND_HALF);

  always_ff @(posedge clk_i) begin
    x1_q <= W1'(s1x >>> FRAC_BITS);
    y1_q <= W1'(s1y >>> FRAC_BITS);
    z1_q <= W1'(z0_q);
  end

  // stage 3/4: pitch
  logic signed [M2-1:0] p2a_q, p2b_q, p2c_q, p2d_q;
  logic signed [W1-1:0] y1d_q;
  logic signed [M2:0]   s2x, s2z;
  logic signed [W2-1:0] x2_q, y2_q, z2_q;

  always_ff @(posedge clk_i) begin
    p2a_q <= M2'(pc) * M2'(x1_q);
    p2b_q <= M2'(ps) * M2'(z1_q);
    p2c_q <= M2'(ps) * M2'(x1_q);
    p2d_q <= M2'(pc) * M2'(z1_q);
    y1d_q <= y1_q;
  end

  assign s2x = (M2+1)'(p2a_q) - (M2+1)'(p2b_q) + (M2+1)'(ROUND_HALF);
  assign s2z = (M2+1)'(p2c_q) + (M2+1)'(p2d_q) + (M2+1)'(ROUND_HALF);

  always_ff @(posedge clk_i) begin
    x2_q <= W2'(s2x >>> FRAC_BITS);
    z2_q <= W2'(s2z >>> FRAC_BITS);
    y2_q <= W2'(y1d_q);
  end

  // stage 5/6: roll
  logic signed [M3-1:0] p3a_q, p3b_q, p3c_q, p3d_q;
  logic signed [W2-1:0] x2d_q;
  logic signed [M3:0]   s3y, s3z;
  logic signed [W3-1:0] x3_q, y3_q, z3_q;

  always_ff @(posedge clk_i) begin
    p3a_q <= M3'(rc) * M3'(y2_q);
    p3b_q <= M3'(rs) * M3'(z2_q);
    p3c_q <= M3'(rc) * M3'(z2_q);
    p3d_q <= M3'(rs) * M3'(y2_q);
    x2d_q <= x2_q;
  end

  assign s3y = (M3+1)'(p3a_q) + (M3+1)'(p3b_q) + (M3+1)'(ROUND_HALF);
  assign s3z = (M3+1)'(p3c_q) - (M3+1)'(p3d_q) + (M3+1)'(ROUND_HALF);

  always_ff @(posedge clk_i) begin
    y3_q <= W3'(s3y >>> FRAC_BITS);
    z3_q <= W3'(s3z >>> FRAC_BITS);
    x3_q <= W3'(x2d_q);
  end

  // stage 7: whole-unit offset and clamp
  logic signed [SW-1:0] fx, fy, fz;
  logic signed [W0-1:0] ox_q, oy_q, oz_q;

  assign fx = SW'(x3_q) + (SW'(shx_q) <<< COORD_FRAC);
  assign fy = SW'(y3_q) + (SW'(shy_q) <<< COORD_FRAC);
  assign fz = SW'(z3_q) + (SW'(shz_q) <<< COORD_FRAC);

  always_ff @(posedge clk_i) begin
    ox_q <= (fx > SAT_MAX) ? W0'(SAT_MAX) : (fx < SAT_MIN) ? W0'(SAT_MIN) : W0'(fx);
    oy_q <= (fy > SAT_MAX) ? W0'(SAT_MAX) : (fy < SAT_MIN) ? W0'(SAT_MIN) : W0'(fy);
    oz_q <= (fz > SAT_MAX) ? W0'(SAT_MAX) : (fz < SAT_MIN) ? W0'(SAT_MIN) : W0'(fz);
  end

  assign done_o  = v_q[7];
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_z_o = oz_q;

  a_cfg_blocks_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> busy_o)
    else $error("request window open right after a config write");

  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 done_o)
    else $error("accepted request produced no result");

  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, 7)) |-> $past(accept, 7))
    else $error("result without a matching request");

  a_no_req_in_flight_on_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |-> !accept)
    else $error("request taken on a config write");

endmodule

`default_nettype wire

>>> rtl/erasp_trig.sv
`default_nettype none

module erasp_trig #(
  parameter int SINE_TABLE_DEPTH = erasp_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic signed [erasp_pkg::ANGLE_W-1:0] angle_i,
  output logic signed [erasp_pkg::TRIG_W-1:0]       sin_o,
  output logic signed [erasp_pkg::TRIG_W-1:0]       cos_o
);
  import erasp_pkg::*;

  localparam int D     = SINE_TABLE_DEPTH;
  localparam int NW    = $clog2(FULL_TURN * 4 * D);
  localparam int SH    = NW + 13;
  localparam int PW    = $clog2(4 * D + 1);
  localparam int PRW   = SH + PW;
  localparam int IW    = $clog2(D + 1);
  localparam int AW2   = ANGLE_W + 2;
  localparam logic [63:0] RECIP = (64'd1 << SH) / FULL_TURN + 64'd1;

  typedef logic [TRIG_W-2:0] rom_t [0:D];

  // quarter-wave sine, Q30 Taylor series to x^11, rounded to Q14
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] x;
    logic [63:0] t;
    longint      s;
    for (int k = 0; k <= D; k++) begin
      x = (64'(k) * HALF_PI_Q30) / D;
      t = x;
      s = longint'(x);
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 6;
      s = s - longint'(t);
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 20;
      s = s + longint'(t);
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 42;
      s = s - longint'(t);
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 72;
      s = s + longint'(t);
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 110;
      s = s - longint'(t);
      if (s < 0) begin
        s = 0;
      end
      s = (s + 64'sd32768) >>> 16;
      if (s > ONE_Q14) begin
        s = ONE_Q14;
      end
      tbl[k] = (TRIG_W-1)'(s);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [AW2-1:0] r_s;
  logic [NW-1:0]         num_d, num_q;
  logic [PRW-1:0]        prod_d, prod_q;
  logic [PW-1:0]         phase;
  logic [1:0]            quad, quad_c;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         sidx_d, sidx_q, cidx_d, cidx_q;
  logic                  sneg_q, cneg_q, sneg2_q, cneg2_q;
  logic [TRIG_W-2:0]     smag_q, cmag_q;
  logic signed [TRIG_W-1:0] sin_q, cos_q;

  // angle mod one turn, then scale to table phase (+half step for rounding)
  always_comb begin
    if (angle_i < -FULL_TURN) begin
      r_s = AW2'(angle_i) + AW2'(2 * FULL_TURN);
    end else if (angle_i < 0) begin
      r_s = AW2'(angle_i) + AW2'(FULL_TURN);
    end else if (angle_i >= FULL_TURN) begin
      r_s = AW2'(angle_i) - AW2'(FULL_TURN);
    end else begin
      r_s = AW2'(angle_i);
    end
    num_d = NW'(r_s[TURN_W-1:0]) * NW'(4 * D) + NW'(FULL_TURN / 2);
  end

  // divide by one turn through a rounded-up reciprocal that gives the exact quotient
  assign prod_d = PRW'(num_q) * PRW'(RECIP);

  always_comb begin
    phase = prod_q[SH +: PW];
    if (phase == PW'(4 * D)) begin
      phase = '0;
    end
    if (phase < PW'(D)) begin
      quad = 2'd0;
      idx  = IW'(phase);
    end else if (phase < PW'(2 * D)) begin
      quad = 2'd1;
      idx  = IW'(phase - PW'(D));
    end else if (phase < PW'(3 * D)) begin
      quad = 2'd2;
      idx  = IW'(phase - PW'(2 * D));
    end else begin
      quad = 2'd3;
      idx  = IW'(phase - PW'(3 * D));
    end
    quad_c = quad + 2'd1;
    sidx_d = quad[0] ? IW'(D) - idx : idx;
    cidx_d = quad_c[0] ? IW'(D) - idx : idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      prod_q  <= '0;
      sidx_q  <= '0;
      cidx_q  <= '0;
      sneg_q  <= 1'b0;
      cneg_q  <= 1'b0;
      smag_q  <= '0;
      cmag_q  <= '0;
      sneg2_q <= 1'b0;
      cneg2_q <= 1'b0;
      sin_q   <= '0;
      cos_q   <= '0;
    end else begin
      num_q   <= num_d;
      prod_q  <= prod_d;
      sidx_q  <= sidx_d;
      cidx_q  <= cidx_d;
      sneg_q  <= quad[1];
      cneg_q  <= quad_c[1];
      smag_q  <= SINE_ROM[sidx_q];
      cmag_q  <= SINE_ROM[cidx_q];
      sneg2_q <= sneg_q;
      cneg2_q <= cneg_q;
      sin_q   <= sneg2_q ? -$signed({1'b0, smag_q}) : $signed({1'b0, smag_q});
      cos_q   <= cneg2_q ? -$signed({1'b0, cmag_q}) : $signed({1'b0, cmag_q});
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

`default_nettype wire

>>> tb/sv/tb_euler_rotate_and_shift_point.sv
`timescale 1ns / 100ps

module tb_euler_rotate_and_shift_point;
  import erasp_pkg::*;

  localparam int CW      = 24;
  localparam int DEPTH   = 256;
  localparam int STALL_LIMIT = 2000;
  localparam int PIPE_LATENCY = 7;
  // indexes past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [CW-1:0] in_x_i = '0, in_y_i = '0, in_z_i = '0;
  logic done_o;
  logic signed [CW-1:0] out_x_o, out_y_o, out_z_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  euler_rotate_and_shift_point dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_x_i, .in_y_i, .in_z_i,
    .done_o, .out_x_o, .out_y_o, .out_z_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  logic [ANGLE_W-1:0] angle_reg [3];
  logic [SHIFT_W-1:0] shift_reg [3];
  longint sine_quarter [DEPTH+1];
  point_t expected_points [$];
  int errors = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  function automatic longint quarter_value(longint unsigned k);
    longint unsigned x, t;
    longint sum;
    x = (k * HALF_PI_Q30) / DEPTH;
    t = x;
    sum = longint'(x);
    for (int n = 1; n <= 5; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(t);
      else sum += longint'(t);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 32768) >> 16;
    if (sum > ONE_Q14) sum = ONE_Q14;
    return sum;
  endfunction

  function automatic longint sine_of(int p);
    int q, i;
    longint v;
    p = p % (4 * DEPTH);
    q = p / DEPTH;
    i = p % DEPTH;
    v = (q % 2 == 1) ? sine_quarter[DEPTH - i] : sine_quarter[i];
    return (q >= 2) ? -v : v;
  endfunction

  function automatic int phase_of(logic [ANGLE_W-1:0] raw);
    longint a;
    a = longint'($signed(raw)) % FULL_TURN;
    if (a < 0) a += FULL_TURN;
    return int'(((a * 4 * DEPTH + FULL_TURN / 2) / FULL_TURN) % (4 * DEPTH));
  endfunction

  function automatic longint round_frac(longint v);
    return (v + ROUND_HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic point_t rotate_shift(point_t p);
    longint x, y, z, s, c, nx, ny, nz;
    int ph;
    point_t r;
    x = p.x; y = p.y; z = p.z;
    ph = phase_of(angle_reg[CFG_YAW]);
    s = sine_of(ph); c = sine_of(ph + DEPTH);
    nx = round_frac(c * x + s * y);
    ny = round_frac(c * y - s * x);
    x = nx; y = ny;
    ph = phase_of(angle_reg[CFG_PITCH]);
    s = sine_of(ph); c = sine_of(ph + DEPTH);
    nx = round_frac(c * x - s * z);
    nz = round_frac(s * x + c * z);
    x = nx; z = nz;
    ph = phase_of(angle_reg[CFG_ROLL]);
    s = sine_of(ph); c = sine_of(ph + DEPTH);
    ny = round_frac(c * y + s * z);
    nz = round_frac(c * z - s * y);
    y = ny; z = nz;
    x += longint'($signed(shift_reg[0])) * 256;
    y += longint'($signed(shift_reg[1])) * 256;
    z += longint'($signed(shift_reg[2])) * 256;
    r.x = clamp_coord(x); r.y = clamp_coord(y); r.z = clamp_coord(z);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && done_o) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", out_x_o, out_y_o, out_z_o);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (out_x_o !== e.x) begin
          $error("out_x: expected %0d, got %0d", e.x, out_x_o); errors++;
        end
        if (out_y_o !== e.y) begin
          $error("out_y: expected %0d, got %0d", e.y, out_y_o); errors++;
        end
        if (out_z_o !== e.z) begin
          $error("out_z: expected %0d, got %0d", e.z, out_z_o); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    start_i <= 1'b1;
    in_x_i <= x; in_y_i <= y; in_z_i <= z;
    do @(posedge clk_i); while (busy_o);
    expected_points.insert(expected_points.size(), rotate_shift(p));
  endtask

  task automatic random_gap();
    int n;
    if (!gaps_on) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // only while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= CFG_ROLL) angle_reg[idx] = data[ANGLE_W-1:0];
    else if (idx <= CFG_SHIFT_Z) shift_reg[idx - CFG_SHIFT_X] = data;
    cfg_valid_i <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] yaw, logic [CFG_DATA_W-1:0] pitch,
                           logic [CFG_DATA_W-1:0] roll, logic [CFG_DATA_W-1:0] sx,
                           logic [CFG_DATA_W-1:0] sy, logic [CFG_DATA_W-1:0] sz);
    drain();
    write_reg(CFG_YAW, yaw);
    write_reg(CFG_PITCH, pitch);
    write_reg(CFG_ROLL, roll);
    write_reg(CFG_SHIFT_X, sx);
    write_reg(CFG_SHIFT_Y, sy);
    write_reg(CFG_SHIFT_Z, sz);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 8192)) - 4096);
      2: return $urandom_range(0, 1) ? CW'(24'sh7fffff - $urandom_range(0, 255))
                                     : CW'(-24'sh800000 + $urandom_range(0, 255));
      default: return CW'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic test_reset_identity();
    send_point('0, '0, '0); random_gap();
    send_point(24'sh7fffff, -24'sh800000, 24'sd1); random_gap();
    send_point(-24'sh800000, 24'sh7fffff, -24'sd1); random_gap();
    send_point(24'sh555555, -24'sh2aaaab, 24'sh7fffff); random_gap();
  endtask

  task automatic test_quadrant_angles();
    // right angles, a full turn each way, raw values past one turn, and an eighth turn
    logic [CFG_DATA_W-1:0] angles [8] = '{16'd1440, 16'd2880, 16'd4320, 16'hE980,
                                         16'd5760, 16'h1FFF, 16'h2000, 16'd720};
    foreach (angles[i]) begin
      write_all(angles[i], angles[(i + 3) % 8], angles[(i + 5) % 8], 16'd0, 16'd0, 16'd0);
      send_point(24'sh7fffff, 24'sh001234, -24'sh800000); random_gap();
      send_point(24'sh000100, -24'sh000100, 24'sh000100); random_gap();
    end
  endtask

  task automatic test_shift_saturation();
    write_all(16'd0, 16'd0, 16'd0, 16'h7fff, 16'h8000, 16'h7fff);
    send_point(24'sh7fffff, -24'sh800000, '0); random_gap();
    send_point(-24'sh800000, 24'sh7fffff, -24'sh800000); random_gap();
    send_point('0, '0, '0); random_gap();
    write_all(16'd720, 16'd2000, 16'hF000, 16'h8000, 16'h7fff, 16'h8000);
    send_point(24'sh7fffff, 24'sh7fffff, 24'sh7fffff); random_gap();
    send_point(-24'sh800000, -24'sh800000, -24'sh800000); random_gap();
  endtask

  task automatic test_spare_index();
    drain();
    write_reg(CFG_SPARE_LO, 16'hffff);
    write_reg(CFG_SPARE_HI, 16'h1234);
    send_point(24'sh012345, -24'sh054321, 24'sh00abcd); random_gap();
  endtask

  task automatic test_random_configs();
    for (int ph = 0; ph < 11; ph++) begin
      write_all(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      gaps_on = (ph % 4 != 2);
      for (int k = 0; k < 100; k++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        random_gap();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int k = 0; k <= DEPTH; k++) sine_quarter[k] = quarter_value(k);
    for (int k = 0; k < 3; k++) begin
      angle_reg[k] = '0; shift_reg[k] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_identity();
    test_quadrant_angles();
    test_shift_saturation();
    test_spare_index();
    test_random_configs();
    drain();
    repeat (PIPE_LATENCY + 3) @(posedge clk_i);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
